// ===== sv/blit_rect_clip_with_source_assert.svh =====
// assertion macros for the blit clipper checker
// depends on nothing; included by the checker file only
`ifndef BLIT_RECT_CLIP_WITH_SOURCE_ASSERT_SVH
`define BLIT_RECT_CLIP_WITH_SOURCE_ASSERT_SVH

// implication checked at every clock edge outside reset
`define BRC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brc assertion failed");

// condition that must never hold outside reset
`define BRC_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("brc assertion failed");

`endif

// ===== sv/brc_pkg.sv =====
// types, constants and helpers shared by the blit clipper modules
// depends on nothing
package brc_pkg;

  localparam int COORD_W         = 24;
  localparam int SIZE_W          = 23;
  localparam int WIDE_W          = 26;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int PROD_W          = SIZE_W + RATIO_FRAC_BITS;
  localparam int DIV_STAGES      = RATIO_FRAC_BITS;
  localparam int SCALE_STAGES    = 4;
  localparam int FRONT_STAGES    = 3;
  localparam int PIPE_DEPTH      = DIV_STAGES + SCALE_STAGES;
  // edges from the one that takes an item to the one that accepts its result
  localparam int LATENCY         = FRONT_STAGES + PIPE_DEPTH + 1;

  localparam logic [1:0] CFG_CLIP_LEFT   = 2'd0;
  localparam logic [1:0] CFG_CLIP_TOP    = 2'd1;
  localparam logic [1:0] CFG_CLIP_RIGHT  = 2'd2;
  localparam logic [1:0] CFG_CLIP_BOTTOM = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [SIZE_W-1:0]  size_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic [RATIO_FRAC_BITS-1:0] ratio_t;

  typedef struct packed {
    coord_t dest_x;
    coord_t dest_y;
    size_t  dest_w;
    size_t  dest_h;
    coord_t src_x;
    coord_t src_y;
    size_t  src_w;
    size_t  src_h;
  } cmd_t;

  typedef struct packed {
    coord_t out_dest_x;
    coord_t out_dest_y;
    size_t  out_dest_w;
    size_t  out_dest_h;
    coord_t out_src_x;
    coord_t out_src_y;
    size_t  out_src_w;
    size_t  out_src_h;
    logic   visible;
  } res_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } clip_t;

  // item state carried alongside the dividers and scalers
  typedef struct packed {
    logic   ovl;
    coord_t dest_x;
    coord_t dest_y;
    size_t  dest_w;
    size_t  dest_h;
    coord_t src_x;
    coord_t src_y;
    size_t  src_w;
    size_t  src_h;
  } job_t;

  typedef struct packed {
    size_t cut;
    size_t size;
  } div_op_t;

  typedef struct packed {
    div_op_t left;
    div_op_t top;
    div_op_t right;
    div_op_t bottom;
  } div_ops_t;

  function automatic wide_t sx_wide(coord_t v);
    return wide_t'({{(WIDE_W-COORD_W){v[COORD_W-1]}}, v});
  endfunction

  function automatic wide_t ux_wide(size_t v);
    return wide_t'({{(WIDE_W-SIZE_W){1'b0}}, v});
  endfunction

  function automatic coord_t sat_coord(wide_t v);
    coord_t r;
    if (v > sx_wide({1'b0, {(COORD_W-1){1'b1}}})) begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < sx_wide({1'b1, {(COORD_W-1){1'b0}}})) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic size_t sat_size(wide_t v);
    size_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > ux_wide('1)) begin
      r = '1;
    end else begin
      r = v[SIZE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/blit_rect_clip_with_source.sv =====
// top level of the blit clipper: config registers, pipeline and result register
// depends on brc_pkg, brc_front, brc_div, brc_scale
//
// Usage: a blit command is presented on cmd_i with start high; it is taken
// at any clock edge where busy is low, and busy stays low, so one command
// can enter every cycle. The result (clipped destination, adjusted source,
// visible flag) appears on res_o with done_o high for exactly one cycle;
// results leave in command order. The receiver cannot hold results off and
// none is needed: the pipeline never stalls. The result passes through 24
// register stages: three front stages (edge sums, intersection, cut lengths),
// the 16-stage ratio dividers (one quotient bit per stage), four scaling
// stages (two multiplies per axis) and the result register.
// The clip window is written through cfg_we_i/cfg_idx_i/cfg_data_i while
// no command is in flight. Reset clears all valid bits and sets the window
// to left = top = 0, right = bottom = 8388607.
module blit_rect_clip_with_source (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  brc_pkg::cmd_t       cmd_i,
  output logic                done_o,
  output brc_pkg::res_t       res_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  brc_pkg::coord_t     cfg_data_i
);

  localparam int PD = brc_pkg::PIPE_DEPTH;
  localparam int DS = brc_pkg::DIV_STAGES;

  brc_pkg::clip_t    clip_q;
  logic              front_vld;
  brc_pkg::job_t     front_job;
  brc_pkg::div_ops_t front_div;
  brc_pkg::ratio_t   r_left, r_top, r_right, r_bottom;
  brc_pkg::job_t     pipe_q [PD];
  logic [PD-1:0]     vld_q;
  brc_pkg::coord_t   sx_out, sy_out;
  brc_pkg::size_t    sw_out, sh_out;
  brc_pkg::job_t     last;
  brc_pkg::res_t     res_d, res_q;
  logic              done_q;

  // no back pressure inside: an item is taken every cycle
  assign busy = 1'b0;

  // clip window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q.left   <= '0;
      clip_q.top    <= '0;
      clip_q.right  <= {1'b0, {(brc_pkg::COORD_W-1){1'b1}}};
      clip_q.bottom <= {1'b0, {(brc_pkg::COORD_W-1){1'b1}}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        brc_pkg::CFG_CLIP_LEFT:   clip_q.left   <= cfg_data_i;
        brc_pkg::CFG_CLIP_TOP:    clip_q.top    <= cfg_data_i;
        brc_pkg::CFG_CLIP_RIGHT:  clip_q.right  <= cfg_data_i;
        brc_pkg::CFG_CLIP_BOTTOM: clip_q.bottom <= cfg_data_i;
        default: ;
      endcase
    end
  end

  brc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .cmd_i   (cmd_i),
    .clip_i  (clip_q),
    .valid_o (front_vld),
    .job_o   (front_job),
    .div_o   (front_div)
  );

  brc_div u_div_left   (.clk_i(clk_i), .op_i(front_div.left),   .ratio_o(r_left));
  brc_div u_div_top    (.clk_i(clk_i), .op_i(front_div.top),    .ratio_o(r_top));
  brc_div u_div_right  (.clk_i(clk_i), .op_i(front_div.right),  .ratio_o(r_right));
  brc_div u_div_bottom (.clk_i(clk_i), .op_i(front_div.bottom), .ratio_o(r_bottom));

  // item state and valid bits alongside dividers and scalers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PD-2:0], front_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= front_job;
    for (int i = 1; i < PD; i++) begin
      pipe_q[i] <= pipe_q[i-1];
    end
  end

  brc_scale u_scale_x (
    .clk_i  (clk_i),
    .pos_i  (pipe_q[DS-1].src_x),
    .len_i  (pipe_q[DS-1].src_w),
    .near_i (r_left),
    .far_i  (r_right),
    .pos_o  (sx_out),
    .len_o  (sw_out)
  );

  brc_scale u_scale_y (
    .clk_i  (clk_i),
    .pos_i  (pipe_q[DS-1].src_y),
    .len_i  (pipe_q[DS-1].src_h),
    .near_i (r_top),
    .far_i  (r_bottom),
    .pos_o  (sy_out),
    .len_o  (sh_out)
  );

  // result assembly: zeros when there is no overlap
  assign last = pipe_q[PD-1];

  always_comb begin
    res_d = '0;
    if (last.ovl) begin
      res_d.out_dest_x = last.dest_x;
      res_d.out_dest_y = last.dest_y;
      res_d.out_dest_w = last.dest_w;
      res_d.out_dest_h = last.dest_h;
      res_d.out_src_x  = sx_out;
      res_d.out_src_y  = sy_out;
      res_d.out_src_w  = sw_out;
      res_d.out_src_h  = sh_out;
      res_d.visible    = (last.dest_w != '0) && (last.dest_h != '0)
                         && (sw_out != '0) && (sh_out != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[PD-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== sv/brc_front.sv =====
// front end: intersection with the clip window, cut lengths and divider operands
// depends on brc_pkg
module brc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  brc_pkg::cmd_t     cmd_i,
  input  brc_pkg::clip_t    clip_i,
  output logic              valid_o,
  output brc_pkg::job_t     job_o,
  output brc_pkg::div_ops_t div_o
);

  logic              a_vld_q, b_vld_q, c_vld_q;
  brc_pkg::cmd_t     a_cmd_q, b_cmd_q;
  brc_pkg::wide_t    a_dx1_q, a_dy1_q, b_dx1_q, b_dy1_q;
  brc_pkg::wide_t    b_ix0_q, b_ix1_q, b_iy0_q, b_iy1_q;
  brc_pkg::wide_t    a_dx0, a_dy0, clip_l, clip_t, clip_r, clip_b;
  logic              ovl_x, ovl_y, ovl;
  brc_pkg::wide_t    cut_l, cut_t, cut_r, cut_b, size_r, size_b, dw, dh;
  brc_pkg::job_t     job_d, job_q;
  brc_pkg::div_ops_t div_d, div_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  // stage a: far edges of the destination
  always_ff @(posedge clk_i) begin
    a_cmd_q <= cmd_i;
    a_dx1_q <= brc_pkg::sx_wide(cmd_i.dest_x) + brc_pkg::ux_wide(cmd_i.dest_w);
    a_dy1_q <= brc_pkg::sx_wide(cmd_i.dest_y) + brc_pkg::ux_wide(cmd_i.dest_h);
  end

  assign a_dx0  = brc_pkg::sx_wide(a_cmd_q.dest_x);
  assign a_dy0  = brc_pkg::sx_wide(a_cmd_q.dest_y);
  assign clip_l = brc_pkg::sx_wide(clip_i.left);
  assign clip_t = brc_pkg::sx_wide(clip_i.top);
  assign clip_r = brc_pkg::sx_wide(clip_i.right);
  assign clip_b = brc_pkg::sx_wide(clip_i.bottom);

  // stage b: intersection rectangle
  always_ff @(posedge clk_i) begin
    b_cmd_q <= a_cmd_q;
    b_dx1_q <= a_dx1_q;
    b_dy1_q <= a_dy1_q;
    b_ix0_q <= (a_dx0 > clip_l) ? a_dx0 : clip_l;
    b_iy0_q <= (a_dy0 > clip_t) ? a_dy0 : clip_t;
    b_ix1_q <= (a_dx1_q < clip_r) ? a_dx1_q : clip_r;
    b_iy1_q <= (a_dy1_q < clip_b) ? a_dy1_q : clip_b;
  end

  // stage c: overlap test, cut lengths and clipped sizes
  always_comb begin
    ovl_x  = b_ix1_q > b_ix0_q;
    ovl_y  = b_iy1_q > b_iy0_q;
    ovl    = ovl_x && ovl_y;
    cut_l  = b_ix0_q - brc_pkg::sx_wide(b_cmd_q.dest_x);
    cut_t  = b_iy0_q - brc_pkg::sx_wide(b_cmd_q.dest_y);
    cut_r  = b_dx1_q - b_ix1_q;
    cut_b  = b_dy1_q - b_iy1_q;
    size_r = b_dx1_q - b_ix0_q;
    size_b = b_dy1_q - b_iy0_q;
    dw     = b_ix1_q - b_ix0_q;
    dh     = b_iy1_q - b_iy0_q;

    job_d.ovl    = ovl;
    job_d.dest_x = b_ix0_q[brc_pkg::COORD_W-1:0];
    job_d.dest_y = b_iy0_q[brc_pkg::COORD_W-1:0];
    job_d.dest_w = brc_pkg::sat_size(dw);
    job_d.dest_h = brc_pkg::sat_size(dh);
    job_d.src_x  = b_cmd_q.src_x;
    job_d.src_y  = b_cmd_q.src_y;
    job_d.src_w  = b_cmd_q.src_w;
    job_d.src_h  = b_cmd_q.src_h;

    // with no overlap every cut is zero so the dividers see nothing to do
    div_d.left.cut    = ovl ? cut_l[brc_pkg::SIZE_W-1:0] : '0;
    div_d.left.size   = b_cmd_q.dest_w;
    div_d.top.cut     = ovl ? cut_t[brc_pkg::SIZE_W-1:0] : '0;
    div_d.top.size    = b_cmd_q.dest_h;
    div_d.right.cut   = ovl ? cut_r[brc_pkg::SIZE_W-1:0] : '0;
    div_d.right.size  = size_r[brc_pkg::SIZE_W-1:0];
    div_d.bottom.cut  = ovl ? cut_b[brc_pkg::SIZE_W-1:0] : '0;
    div_d.bottom.size = size_b[brc_pkg::SIZE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    div_q <= div_d;
  end

  assign valid_o = c_vld_q;
  assign job_o   = job_q;
  assign div_o   = div_q;

endmodule

// ===== sv/brc_div.sv =====
// pipelined restoring divider for cut ratios, one quotient bit per stage
// depends on brc_pkg
module brc_div (
  input  logic             clk_i,
  input  brc_pkg::div_op_t op_i,
  output brc_pkg::ratio_t  ratio_o
);

  localparam int N = brc_pkg::DIV_STAGES;

  brc_pkg::size_t  rem_q [N];
  brc_pkg::size_t  dvs_q [N];
  brc_pkg::ratio_t quo_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    brc_pkg::size_t              rem_in, dvs_in, rem_nx;
    brc_pkg::ratio_t             quo_in;
    logic [brc_pkg::SIZE_W:0]    r2;
    logic                        ge;

    if (i == 0) begin : g_first
      assign rem_in = op_i.cut;
      assign dvs_in = op_i.size;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign dvs_in = dvs_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    // shift in one dividend bit and try to subtract the divisor
    always_comb begin
      r2     = {rem_in, 1'b0};
      ge     = (dvs_in != '0) && (r2 >= {1'b0, dvs_in});
      rem_nx = ge ? brc_pkg::size_t'(r2 - {1'b0, dvs_in}) : r2[brc_pkg::SIZE_W-1:0];
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= rem_nx;
      dvs_q[i] <= dvs_in;
      quo_q[i] <= {quo_in[brc_pkg::RATIO_FRAC_BITS-2:0], ge};
    end
  end

  assign ratio_o = quo_q[N-1];

endmodule

// ===== sv/brc_scale.sv =====
// source adjustment along one axis: near cut then far cut, two multiplies
// depends on brc_pkg
module brc_scale (
  input  logic            clk_i,
  input  brc_pkg::coord_t pos_i,
  input  brc_pkg::size_t  len_i,
  input  brc_pkg::ratio_t near_i,
  input  brc_pkg::ratio_t far_i,
  output brc_pkg::coord_t pos_o,
  output brc_pkg::size_t  len_o
);

  localparam int PW = brc_pkg::PROD_W;
  localparam int FB = brc_pkg::RATIO_FRAC_BITS;

  logic [PW-1:0]   p1_prod_q, p3_prod_q;
  brc_pkg::coord_t p1_pos_q;
  brc_pkg::size_t  p1_len_q, p2_len_q, p3_len_q, len_q;
  brc_pkg::ratio_t p1_far_q, p2_far_q;
  brc_pkg::wide_t  p2_pos_q, p3_pos_q;
  brc_pkg::coord_t pos_q;
  brc_pkg::size_t  near_d, far_d;

  assign near_d = p1_prod_q[PW-1:FB];
  assign far_d  = p3_prod_q[PW-1:FB];

  // stage 1: near cut product
  always_ff @(posedge clk_i) begin
    p1_prod_q <= PW'(len_i) * PW'(near_i);
    p1_pos_q  <= pos_i;
    p1_len_q  <= len_i;
    p1_far_q  <= far_i;
  end

  // stage 2: move origin forward, shrink length
  always_ff @(posedge clk_i) begin
    p2_len_q <= p1_len_q - near_d;
    p2_pos_q <= brc_pkg::sx_wide(p1_pos_q) + brc_pkg::ux_wide(near_d);
    p2_far_q <= p1_far_q;
  end

  // stage 3: far cut product on the shrunk length
  always_ff @(posedge clk_i) begin
    p3_prod_q <= PW'(p2_len_q) * PW'(p2_far_q);
    p3_pos_q  <= p2_pos_q;
    p3_len_q  <= p2_len_q;
  end

  // stage 4: final length and saturated origin
  always_ff @(posedge clk_i) begin
    len_q <= p3_len_q - far_d;
    pos_q <= brc_pkg::sat_coord(p3_pos_q);
  end

  assign pos_o = pos_q;
  assign len_o = len_q;

endmodule

// ===== sv/brc_checker.sv =====
// port-level checker for the blit clipper, bound to the top level
// depends on brc_pkg and blit_rect_clip_with_source_assert.svh
`include "blit_rect_clip_with_source_assert.svh"

module brc_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input brc_pkg::res_t   res_o
);

  logic vis_res, sizes_pos, empty_res;

  assign vis_res   = done_o && res_o.visible;
  assign sizes_pos = (res_o.out_dest_w != '0) && (res_o.out_dest_h != '0)
                     && (res_o.out_src_w != '0) && (res_o.out_src_h != '0);
  assign empty_res = done_o && (res_o.out_dest_w == '0);

  // every result comes from an item taken a fixed latency earlier
  `BRC_ASSERT_IMP(a_latency, clk_i, rst_ni, done_o, $past(start && !busy, brc_pkg::LATENCY))

  // a visible result has all four sizes positive
  `BRC_ASSERT_IMP(a_visible_sizes, clk_i, rst_ni, vis_res, sizes_pos)

  // an empty destination only comes from a rejected item, which is all zeros
  `BRC_ASSERT_IMP(a_empty_is_zero, clk_i, rst_ni, empty_res, res_o == '0)

  // busy never rises: an item can enter every cycle
  `BRC_ASSERT_NEVER(a_busy_low, clk_i, rst_ni, busy)

endmodule

bind blit_rect_clip_with_source brc_checker u_brc_checker (.*);

// ===== sim/tb.sv =====
// testbench for blit_rect_clip_with_source: directed table, then random blit commands
// depends on brc_pkg and the blit_rect_clip_with_source rtl
// results are predicted per command and checked field by field in command order
module tb;

  localparam longint MAX24 = 8388607;
  localparam longint MIN24 = -8388608;
  localparam longint ONE_FRAC = 64'd1 << brc_pkg::RATIO_FRAC_BITS;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  brc_pkg::cmd_t cmd_i = '0;
  logic done_o;
  brc_pkg::res_t res_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = brc_pkg::CFG_CLIP_LEFT;
  brc_pkg::coord_t cfg_data_i = '0;

  typedef struct {
    brc_pkg::cmd_t c;
    bit            typed;
    brc_pkg::res_t want;
  } row_t;

  longint        win_left, win_top, win_right, win_bottom;
  brc_pkg::res_t pending_res[$];
  row_t          rows[$];
  int            errors = 0;
  int            cycles = 0;
  int            gap_max = 17;

  blit_rect_clip_with_source dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd_i),
    .done_o(done_o), .res_o(res_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // cut fraction with 16 fraction bits, capped at one
  function automatic longint cut_frac(longint cut, longint size);
    longint r;
    if (size <= 0 || cut >= size) return ONE_FRAC;
    if (cut <= 0) return 0;
    r = (cut << brc_pkg::RATIO_FRAC_BITS) / size;
    return (r > ONE_FRAC) ? ONE_FRAC : r;
  endfunction

  function automatic longint shrink(longint len, longint frac);
    return (len * frac) >>> brc_pkg::RATIO_FRAC_BITS;
  endfunction

  function automatic brc_pkg::coord_t clamp_coord(longint v);
    if (v > MAX24) v = MAX24;
    if (v < MIN24) v = MIN24;
    return brc_pkg::coord_t'(v);
  endfunction

  function automatic brc_pkg::size_t clamp_size(longint v);
    if (v < 0) v = 0;
    if (v > MAX24) v = MAX24;
    return brc_pkg::size_t'(v);
  endfunction

  // clip the destination to the window and scale the source along with it
  function automatic brc_pkg::res_t clip_blit(brc_pkg::cmd_t c);
    brc_pkg::res_t r;
    longint x0, y0, x1, y1, sx, sy, sw, sh, d, dw, dh;
    longint ix0, ix1, iy0, iy1;
    x0 = longint'(c.dest_x);
    y0 = longint'(c.dest_y);
    x1 = x0 + longint'({1'b0, c.dest_w});
    y1 = y0 + longint'({1'b0, c.dest_h});
    sx = longint'(c.src_x);
    sy = longint'(c.src_y);
    sw = longint'({1'b0, c.src_w});
    sh = longint'({1'b0, c.src_h});
    ix0 = (x0 > win_left) ? x0 : win_left;
    ix1 = (x1 < win_right) ? x1 : win_right;
    iy0 = (y0 > win_top) ? y0 : win_top;
    iy1 = (y1 < win_bottom) ? y1 : win_bottom;
    r = '0;
    if (ix1 - ix0 <= 0 || iy1 - iy0 <= 0) return r;
    if (x0 < win_left) begin
      d = shrink(sw, cut_frac(win_left - x0, x1 - x0));
      x0 = win_left;
      sx += d;
      sw -= d;
    end
    if (y0 < win_top) begin
      d = shrink(sh, cut_frac(win_top - y0, y1 - y0));
      y0 = win_top;
      sy += d;
      sh -= d;
    end
    if (x1 > win_right) begin
      d = shrink(sw, cut_frac(x1 - win_right, x1 - x0));
      x1 = win_right;
      sw -= d;
    end
    if (y1 > win_bottom) begin
      d = shrink(sh, cut_frac(y1 - win_bottom, y1 - y0));
      y1 = win_bottom;
      sh -= d;
    end
    dw = x1 - x0;
    dh = y1 - y0;
    r.out_dest_x = clamp_coord(x0);
    r.out_dest_y = clamp_coord(y0);
    r.out_dest_w = clamp_size(dw);
    r.out_dest_h = clamp_size(dh);
    r.out_src_x  = clamp_coord(sx);
    r.out_src_y  = clamp_coord(sy);
    r.out_src_w  = clamp_size(sw);
    r.out_src_h  = clamp_size(sh);
    r.visible    = (dw > 0 && dh > 0 && sw > 0 && sh > 0);
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    brc_pkg::res_t w;
    if (rst_ni && done_o) begin
      if (pending_res.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        w = pending_res.pop_front();
        if (res_o.out_dest_x !== w.out_dest_x)
          report("out_dest_x", res_o.out_dest_x, w.out_dest_x);
        if (res_o.out_dest_y !== w.out_dest_y)
          report("out_dest_y", res_o.out_dest_y, w.out_dest_y);
        if (res_o.out_dest_w !== w.out_dest_w)
          report("out_dest_w", res_o.out_dest_w, w.out_dest_w);
        if (res_o.out_dest_h !== w.out_dest_h)
          report("out_dest_h", res_o.out_dest_h, w.out_dest_h);
        if (res_o.out_src_x !== w.out_src_x)
          report("out_src_x", res_o.out_src_x, w.out_src_x);
        if (res_o.out_src_y !== w.out_src_y)
          report("out_src_y", res_o.out_src_y, w.out_src_y);
        if (res_o.out_src_w !== w.out_src_w)
          report("out_src_w", res_o.out_src_w, w.out_src_w);
        if (res_o.out_src_h !== w.out_src_h)
          report("out_src_h", res_o.out_src_h, w.out_src_h);
        if (res_o.visible !== w.visible)
          report("visible", res_o.visible, w.visible);
      end
    end
  end

  // present one item after a random gap and wait until it is taken
  task automatic send_item(brc_pkg::cmd_t c, bit typed, brc_pkg::res_t want);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    pending_res = {pending_res, (typed ? want : clip_blit(c))};
  endtask

  // hold the sender until every expected result is in
  task automatic drain();
    start <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
  endtask

  // wait for the pipeline to drain, one register write, then the write port goes idle
  task automatic write_clip(logic [1:0] idx, longint v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= brc_pkg::coord_t'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      brc_pkg::CFG_CLIP_LEFT:   win_left = v;
      brc_pkg::CFG_CLIP_TOP:    win_top = v;
      brc_pkg::CFG_CLIP_RIGHT:  win_right = v;
      brc_pkg::CFG_CLIP_BOTTOM: win_bottom = v;
      default: ;
    endcase
  endtask

  task automatic set_window(longint l, longint t, longint r, longint b);
    write_clip(brc_pkg::CFG_CLIP_LEFT, l);
    write_clip(brc_pkg::CFG_CLIP_TOP, t);
    write_clip(brc_pkg::CFG_CLIP_RIGHT, r);
    write_clip(brc_pkg::CFG_CLIP_BOTTOM, b);
  endtask

  function automatic brc_pkg::cmd_t mk_cmd(longint dx, longint dy, longint dw, longint dh,
                                           longint sx, longint sy, longint sw, longint sh);
    brc_pkg::cmd_t c;
    c.dest_x = brc_pkg::coord_t'(dx);
    c.dest_y = brc_pkg::coord_t'(dy);
    c.dest_w = brc_pkg::size_t'(dw);
    c.dest_h = brc_pkg::size_t'(dh);
    c.src_x  = brc_pkg::coord_t'(sx);
    c.src_y  = brc_pkg::coord_t'(sy);
    c.src_w  = brc_pkg::size_t'(sw);
    c.src_h  = brc_pkg::size_t'(sh);
    return c;
  endfunction

  function automatic void add_row(brc_pkg::cmd_t c, bit typed, brc_pkg::res_t want);
    row_t r;
    r.c = c;
    r.typed = typed;
    r.want = want;
    rows = {rows, r};
  endfunction

  // size with a random magnitude, mostly small
  function automatic longint rand_size();
    int sh;
    sh = $urandom_range(0, 23);
    return longint'($urandom) & ((64'd1 << sh) - 1);
  endfunction

  // coordinate near a window edge
  function automatic longint near_edge(longint e);
    longint off;
    off = rand_size();
    return longint'(clamp_coord(($urandom_range(0, 1) != 0) ? e + off : e - off));
  endfunction

  // mostly commands straddling the window, some fully random noise
  function automatic brc_pkg::cmd_t rand_cmd();
    brc_pkg::cmd_t c;
    if ($urandom_range(0, 7) == 0) begin
      c.dest_x = brc_pkg::coord_t'($urandom);
      c.dest_y = brc_pkg::coord_t'($urandom);
      c.dest_w = brc_pkg::size_t'($urandom);
      c.dest_h = brc_pkg::size_t'($urandom);
      c.src_x  = brc_pkg::coord_t'($urandom);
      c.src_y  = brc_pkg::coord_t'($urandom);
      c.src_w  = brc_pkg::size_t'($urandom);
      c.src_h  = brc_pkg::size_t'($urandom);
    end else begin
      c.dest_x = brc_pkg::coord_t'(near_edge(($urandom_range(0, 1) != 0) ? win_left
                                                                       : win_right));
      c.dest_y = brc_pkg::coord_t'(near_edge(($urandom_range(0, 1) != 0) ? win_top
                                                                       : win_bottom));
      c.dest_w = brc_pkg::size_t'(rand_size());
      c.dest_h = brc_pkg::size_t'(rand_size());
      c.src_x  = brc_pkg::coord_t'($urandom);
      c.src_y  = brc_pkg::coord_t'($urandom);
      c.src_w  = brc_pkg::size_t'(rand_size());
      c.src_h  = brc_pkg::size_t'(rand_size());
    end
    return c;
  endfunction

  task automatic random_phase(int n);
    brc_pkg::res_t none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      // every 40 items pick either back-to-back traffic or random gaps
      if (i % 40 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
      send_item(rand_cmd(), 1'b0, none);
    end
  endtask

  initial begin
    brc_pkg::res_t zero, same;
    brc_pkg::cmd_t c;
    zero = '0;
    win_left = 0;
    win_top = 0;
    win_right = MAX24;
    win_bottom = MAX24;

    // directed rows against the reset window
    c = mk_cmd(256, 256, 1024, 512, 100, -200, 2048, 300);
    same = '{c.dest_x, c.dest_y, c.dest_w, c.dest_h, c.src_x, c.src_y, c.src_w,
             c.src_h, 1'b1};
    add_row(c, 1'b1, same);
    // empty destination gives no overlap
    add_row(mk_cmd(256, 256, 0, 512, 1, 2, 3, 4), 1'b1, zero);
    add_row(mk_cmd(256, 256, 512, 0, 1, 2, 3, 4), 1'b1, zero);
    // destination entirely left of and above the window
    add_row(mk_cmd(MIN24, 100, 100, 100, 5, 5, 9, 9), 1'b1, zero);
    add_row(mk_cmd(100, MIN24, 100, 100, 5, 5, 9, 9), 1'b1, zero);
    // zero source size stays inside, invisible
    c = mk_cmd(10, 10, 10, 10, 7, 7, 0, 5);
    same = '{c.dest_x, c.dest_y, c.dest_w, c.dest_h, c.src_x, c.src_y, c.src_w,
             c.src_h, 1'b0};
    add_row(c, 1'b1, same);
    // left, top and combined cuts
    add_row(mk_cmd(-512, 100, 1024, 100, 0, 0, 4096, 256), 1'b0, zero);
    add_row(mk_cmd(100, -512, 100, 1024, 0, 0, 256, 4096), 1'b0, zero);
    add_row(mk_cmd(-300, -700, 1000, 1000, -50, 60, 777, 333), 1'b0, zero);
    // right and bottom cuts at the far edge, and extremes with no overlap
    add_row(mk_cmd(8388000, 100, MAX24, 100, 0, 0, MAX24, 256), 1'b0, zero);
    add_row(mk_cmd(100, 8388000, 100, MAX24, 0, 0, 256, MAX24), 1'b0, zero);
    add_row(mk_cmd(MIN24, MIN24, MAX24, MAX24, MIN24, MIN24, MAX24, MAX24), 1'b0, zero);
    add_row(mk_cmd(MAX24, MAX24, MAX24, MAX24, 0, 0, 1, 1), 1'b0, zero);
    // source origin overflow on left and top cuts; the first row does not overlap
    add_row(mk_cmd(-MAX24, -MAX24, MAX24, MAX24, MAX24, MAX24, MAX24, MAX24),
            1'b0, zero);
    add_row(mk_cmd(-1, -1, 2, 2, MAX24, MAX24, MAX24, MAX24), 1'b0, zero);
    // touching edge only, no overlap
    add_row(mk_cmd(-100, 0, 100, 10, 0, 0, 10, 10), 1'b1, zero);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_max = 17;
    foreach (rows[i]) send_item(rows[i].c, rows[i].typed, rows[i].want);

    random_phase(200);
    // widest window
    set_window(MIN24, MIN24, MAX24, MAX24);
    random_phase(200);
    // small window in the middle
    set_window(-4096, 2048, 8192, 6000);
    random_phase(250);
    // inverted window: every result zero
    set_window(MAX24, 0, MIN24, 100);
    random_phase(100);
    // narrowest extremes
    set_window(MIN24, MAX24 - 256, MIN24 + 256, MAX24);
    random_phase(150);
    // random windows
    for (int k = 0; k < 6; k++) begin
      set_window(longint'(brc_pkg::coord_t'($urandom)) >>> $urandom_range(0, 12),
                 longint'(brc_pkg::coord_t'($urandom)) >>> $urandom_range(0, 12),
                 longint'(brc_pkg::coord_t'($urandom)) >>> $urandom_range(0, 12),
                 longint'(brc_pkg::coord_t'($urandom)) >>> $urandom_range(0, 12));
      random_phase(120);
    end
    // back to the reset window
    set_window(0, 0, MAX24, MAX24);
    random_phase(100);

    drain();
    repeat (brc_pkg::LATENCY + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== blit_rect_clip_with_source.f =====
+incdir+sv
sv/brc_pkg.sv
sv/brc_front.sv
sv/brc_div.sv
sv/brc_scale.sv
sv/blit_rect_clip_with_source.sv
sv/brc_checker.sv
sim/tb.sv
